// ----- hw/rtl/fpba_pkg.sv -----
// Shared types, codes and control store layout for the fit policy block allocator.
`default_nettype none

package fpba_pkg;

	// Default sizes of the free-size table
	localparam int DEF_NUM_BLOCKS = 16;
	localparam int DEF_SIZE_BITS  = 16;

	// Fixed payload widths on the stream ports
	localparam int IDX_FIELD_W  = 4;
	localparam int SIZE_FIELD_W = 16;
	localparam int STAT_FIELD_W = 2;
	localparam int S_TDATA_W    = 24;
	localparam int M_TDATA_W    = 24;

	// Configuration register indexes (paddr[2])
	localparam logic REG_FIT_POLICY  = 1'b0;
	localparam logic REG_BLOCK_COUNT = 1'b1;

	localparam logic [4:0] BLOCK_COUNT_RST = 5'd16;

	// Placement rules; code three behaves as first fit
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	// Item kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_REQ  = 1'b1;

	// Result status codes
	localparam logic [1:0] STAT_LOADED = 2'd0;
	localparam logic [1:0] STAT_ALLOC  = 2'd1;
	localparam logic [1:0] STAT_NONE   = 2'd2;

	// Step counter codes
	localparam int UPC_W = 3;
	localparam logic [UPC_W-1:0] STEP_IDLE  = 3'd0;
	localparam logic [UPC_W-1:0] STEP_INIT  = 3'd1;
	localparam logic [UPC_W-1:0] STEP_SCAN  = 3'd2;
	localparam logic [UPC_W-1:0] STEP_ALLOC = 3'd3;
	localparam logic [UPC_W-1:0] STEP_LOAD  = 3'd4;

	// Datapath operations
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_ACCEPT = 3'd1;
	localparam logic [2:0] OP_INIT   = 3'd2;
	localparam logic [2:0] OP_SCAN   = 3'd3;
	localparam logic [2:0] OP_ALLOC  = 3'd4;
	localparam logic [2:0] OP_LOAD   = 3'd5;

	// Jump conditions
	localparam logic [2:0] COND_ALWAYS    = 3'd0;
	localparam logic [2:0] COND_NO_ITEM   = 3'd1;
	localparam logic [2:0] COND_IS_LOAD   = 3'd2;
	localparam logic [2:0] COND_SCAN_MORE = 3'd3;
	localparam logic [2:0] COND_OUT_FULL  = 3'd4;

	typedef struct packed {
		logic [2:0]       op;
		logic [2:0]       cond;
		logic [UPC_W-1:0] jt;   // next step when the condition holds
		logic [UPC_W-1:0] jf;   // next step otherwise
	} ctl_word_t;

	typedef struct packed {
		logic item_taken;
		logic is_load;
		logic scan_more;
		logic out_full;
	} dp_flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fpba_ucode_rom.sv -----
// Control store: one control word per sequencer step.
`default_nettype none

module fpba_ucode_rom
	import fpba_pkg::*;
(
	input  wire logic [UPC_W-1:0] upc,
	output ctl_word_t             ctl
);

	always_comb begin
		unique case (upc)
			STEP_IDLE:  ctl = '{op: OP_ACCEPT, cond: COND_NO_ITEM,
			                    jt: STEP_IDLE,  jf: STEP_INIT};
			STEP_INIT:  ctl = '{op: OP_INIT,   cond: COND_IS_LOAD,
			                    jt: STEP_LOAD,  jf: STEP_SCAN};
			STEP_SCAN:  ctl = '{op: OP_SCAN,   cond: COND_SCAN_MORE,
			                    jt: STEP_SCAN,  jf: STEP_ALLOC};
			STEP_ALLOC: ctl = '{op: OP_ALLOC,  cond: COND_OUT_FULL,
			                    jt: STEP_ALLOC, jf: STEP_IDLE};
			STEP_LOAD:  ctl = '{op: OP_LOAD,   cond: COND_OUT_FULL,
			                    jt: STEP_LOAD,  jf: STEP_IDLE};
			default:    ctl = '{op: OP_NONE,   cond: COND_ALWAYS,
			                    jt: STEP_IDLE,  jf: STEP_IDLE};
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/fpba_sequencer.sv -----
// Step counter with conditional jumps over the control store.
`default_nettype none

module fpba_sequencer
	import fpba_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire dp_flags_t flags,
	output ctl_word_t      ctl
);

	logic [UPC_W-1:0] upc_q;
	logic             take;

	fpba_ucode_rom u_rom (
		.upc (upc_q),
		.ctl (ctl)
	);

	always_comb begin
		unique case (ctl.cond)
			COND_NO_ITEM:   take = !flags.item_taken;
			COND_IS_LOAD:   take = flags.is_load;
			COND_SCAN_MORE: take = flags.scan_more;
			COND_OUT_FULL:  take = flags.out_full;
			default:        take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_IDLE;
		end else begin
			upc_q <= take ? ctl.jt : ctl.jf;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		flags.item_taken |=> upc_q == STEP_INIT)
		else $error("accepted word did not start the program");

	a_alloc_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == STEP_ALLOC && flags.out_full) |=> upc_q == STEP_ALLOC)
		else $error("allocation step left while output was full");

endmodule

`default_nettype wire

// ----- hw/rtl/fpba_datapath.sv -----
// Free-size table, scan registers and output register driven by the control word.
`default_nettype none

module fpba_datapath
	import fpba_pkg::*;
#(
	parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
	parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ctl_word_t               ctl,
	output dp_flags_t                    flags,
	input  wire logic [1:0]              fit_policy,
	input  wire logic [4:0]              block_count,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    in_kind,
	input  wire logic [IDX_FIELD_W-1:0]  in_index,
	input  wire logic [SIZE_FIELD_W-1:0] in_size,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [STAT_FIELD_W-1:0]      out_status,
	output logic [IDX_FIELD_W-1:0]       out_block,
	output logic [SIZE_FIELD_W-1:0]      out_left
);

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	logic [SIZE_BITS-1:0]   mem_q [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0]  valid_q;
	logic [SIZE_BITS-1:0]   rd_q;

	logic                   item_kind_q;
	logic [IDX_FIELD_W-1:0] item_idx_q;
	logic [SIZE_BITS-1:0]   size_q;

	logic [IDX_W-1:0]       cmp_idx_q;
	logic                   found_q;
	logic [IDX_W-1:0]       pick_q;
	logic [SIZE_BITS-1:0]   best_q;

	logic                   out_valid_q;
	logic [STAT_FIELD_W-1:0] out_status_q;
	logic [IDX_FIELD_W-1:0] out_block_q;
	logic [SIZE_FIELD_W-1:0] out_left_q;

	logic [CNT_W-1:0]       used;
	logic [CNT_W-1:0]       scan_next;
	logic                   in_use;
	logic                   fits;
	logic                   first_fit;
	logic                   take_item;
	logic                   out_full;
	logic                   fire;
	logic                   idx_ok;
	logic [SIZE_BITS-1:0]   remain;
	logic [IDX_W-1:0]       rd_addr;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [SIZE_BITS-1:0]   wr_data;

	// Entries in use saturate at the table depth
	always_comb begin
		if (32'(block_count) > NUM_BLOCKS) begin
			used = CNT_W'(NUM_BLOCKS);
		end else begin
			used = CNT_W'(block_count);
		end
	end

	assign first_fit = (fit_policy != POL_BEST) && (fit_policy != POL_WORST);
	assign scan_next = CNT_W'(cmp_idx_q) + CNT_W'(1);
	assign in_use    = CNT_W'(cmp_idx_q) < used;
	assign fits      = in_use && (rd_q >= size_q);
	assign remain    = best_q - size_q;
	assign idx_ok    = 32'(item_idx_q) < NUM_BLOCKS;

	assign in_ready  = (ctl.op == OP_ACCEPT);
	assign take_item = in_ready && in_valid;
	assign out_full  = out_valid_q && !out_ready;
	assign fire      = !out_full;

	assign flags.item_taken = take_item;
	assign flags.is_load    = (item_kind_q == KIND_LOAD);
	assign flags.scan_more  = (scan_next < used) && !(first_fit && fits);
	assign flags.out_full   = out_full;

	// Prefetch the next entry while the current one is compared
	assign rd_addr = (ctl.op == OP_SCAN) ? IDX_W'(scan_next) : '0;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pick_q;
		wr_data = remain;
		if (ctl.op == OP_LOAD) begin
			wr_en   = fire && idx_ok;
			wr_addr = IDX_W'(item_idx_q);
			wr_data = size_q;
		end else if (ctl.op == OP_ALLOC) begin
			wr_en   = fire && found_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= valid_q[rd_addr] ? mem_q[rd_addr] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (take_item) begin
			item_kind_q <= in_kind;
			item_idx_q  <= in_index;
			size_q      <= SIZE_BITS'(in_size);
		end
	end

	// Scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_idx_q <= '0;
			found_q   <= 1'b0;
		end else if (ctl.op == OP_INIT) begin
			cmp_idx_q <= '0;
			found_q   <= 1'b0;
		end else if (ctl.op == OP_SCAN) begin
			cmp_idx_q <= cmp_idx_q + IDX_W'(1);
			if (fits) begin
				found_q <= 1'b1;
			end
		end
	end

	// Candidate tracking; ties keep the lower index
	always_ff @(posedge clk) begin
		if (ctl.op == OP_SCAN && fits) begin
			if (!found_q) begin
				pick_q <= cmp_idx_q;
				best_q <= rd_q;
			end else if (fit_policy == POL_BEST && rd_q < best_q) begin
				pick_q <= cmp_idx_q;
				best_q <= rd_q;
			end else if (fit_policy == POL_WORST && rd_q > best_q) begin
				pick_q <= cmp_idx_q;
				best_q <= rd_q;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ctl.op == OP_ALLOC || ctl.op == OP_LOAD) && fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ctl.op == OP_LOAD) begin
			out_status_q <= STAT_LOADED;
			out_block_q  <= item_idx_q;
			out_left_q   <= idx_ok ? SIZE_FIELD_W'(size_q) : '0;
		end else if (fire && ctl.op == OP_ALLOC) begin
			out_status_q <= found_q ? STAT_ALLOC : STAT_NONE;
			out_block_q  <= found_q ? IDX_FIELD_W'(pick_q) : '0;
			out_left_q   <= found_q ? SIZE_FIELD_W'(remain) : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_block  = out_block_q;
	assign out_left   = out_left_q;

	a_first_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_SCAN && fits && !found_q) |=>
		(found_q && pick_q == $past(cmp_idx_q)))
		else $error("first fitting entry not captured");

	a_best_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_SCAN && found_q && fit_policy == POL_BEST) |=>
		(best_q <= $past(best_q)))
		else $error("best fit candidate grew");

	a_alloc_status: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_ALLOC && fire) |=>
		(out_valid_q && out_status_q == ($past(found_q) ? STAT_ALLOC : STAT_NONE)))
		else $error("allocation result status wrong");

endmodule

`default_nettype wire

// ----- hw/rtl/fit_policy_block_allocator_unit.sv -----
// Top level of the fit policy block allocator: stream ports, APB registers, sequencer.
//
// Input words (s_*) carry a load or an allocation request; tuser holds the kind
// (0 load, 1 request), tdata the block index and size. Each input word gives
// exactly one result word on m_*: tuser holds the status (0 loaded, 1 allocated,
// 2 not allocated), tdata the chosen block and the free size left in it.
// A load passes the idle, init and load steps, a request the idle, init, scan and
// alloc steps; no new word is accepted before the idle step returns. Scan steps read
// one table entry per cycle through the table's single read port, at least one, at
// most the entries in use (one if none are). First fit stops at the first fitting
// entry; best and worst fit scan all of them. The user must write fit_policy
// (address 0) and block_count (address 4) over APB only while the block is idle; the
// block itself does not enforce this. Writes take effect for the next word.
// Reset clears the table (per-entry valid bits), sets first fit and sixteen
// blocks, and empties the output register.
// While the receiver stalls, the result holds in the output register and the
// block still accepts one more word; it then waits until the register drains.
`default_nettype none

module fit_policy_block_allocator_unit
	import fpba_pkg::*;
#(
	parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
	parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,   // load_index[3:0], size_value[19:4], zero
	input  wire logic                 s_tuser,   // kind[0]

	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,   // chosen_block[3:0], left_over[19:4], zero
	output logic [STAT_FIELD_W-1:0]   m_tuser,   // status[1:0]

	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [2:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	logic [1:0]              fit_policy_q;
	logic [4:0]              block_count_q;
	logic                    cfg_wr;

	ctl_word_t               ctl;
	dp_flags_t               flags;
	logic [IDX_FIELD_W-1:0]  out_block;
	logic [SIZE_FIELD_W-1:0] out_left;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q  <= POL_FIRST;
			block_count_q <= BLOCK_COUNT_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_FIT_POLICY) begin
				fit_policy_q <= pwdata[1:0];
			end else begin
				block_count_q <= pwdata[4:0];
			end
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FIT_POLICY:  prdata = {30'd0, fit_policy_q};
			REG_BLOCK_COUNT: prdata = {27'd0, block_count_q};
			default:         prdata = '0;
		endcase
	end

	fpba_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	fpba_datapath #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.flags       (flags),
		.fit_policy  (fit_policy_q),
		.block_count (block_count_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_kind     (s_tuser),
		.in_index    (s_tdata[3:0]),
		.in_size     (s_tdata[19:4]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_status  (m_tuser),
		.out_block   (out_block),
		.out_left    (out_left)
	);

	assign m_tdata = {4'd0, out_left, out_block};

endmodule

`default_nettype wire
